### hw/rtl/bbdc_pkg.sv
// Shared types and constants of the block bitmap duplicate checker.
// Depends on nothing; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package bbdc_pkg;

   // default map size in blocks
   localparam int DEF_MAX_BLOCKS = 65536;

   // bits per map row and bit-select width
   localparam int MAP_ROW_BITS = 32;
   localparam int MAP_BIT_W    = 5;

   // fixed field widths
   localparam int BLOCK_NUM_W = 32;
   localparam int CNT_W       = 17;
   localparam int DUP_W       = 16;
   localparam int STATUS_W    = 3;
   localparam int CLASS_W     = 2;

   // operation codes
   localparam logic OP_MARK  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // block class codes
   localparam logic [CLASS_W-1:0] CLASS_SYSTEM = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_FREE   = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_FILE   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE_FREE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OWNED_DUP = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FREE_DUP  = 3'd4;

   // register indexes
   localparam logic CSR_BLOCK_COUNT  = 1'b0;
   localparam logic CSR_REBUILD_MODE = 1'b1;

   // saturation limit of 17-bit counts
   localparam logic [CNT_W-1:0] CNT17_MAX = 17'h1FFFF;

   // controller to datapath
   typedef struct packed {
      logic load_item;   // latch item, issue map row read
      logic eval;        // classify item, update map and counters
      logic clr_step;    // zero one map row, advance clear pointer
      logic rsp_clear;   // post the result of a clear item
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;    // clear pointer sits on the last row
   } dp_status_type;

endpackage

`default_nettype wire

### hw/rtl/bbdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bbdc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/bbdc_ctrl.sv
// Controller of the block bitmap duplicate checker: item sequencing and
// map clearing. Depends on bbdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbdc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic                    req_operation,
   output logic                         busy,
   output bbdc_pkg::ctrl_cmd_type       cmd,
   input  wire bbdc_pkg::dp_status_type dp_status
);

   import bbdc_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EVAL  = 2'd1;
   localparam logic [1:0] S_CLEAR = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       clr_rsp_ff, clr_rsp_in;   // clear pass was started by an item
   logic       accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      clr_rsp_in = clr_rsp_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               if (req_operation == OP_CLEAR) begin
                  state_in   = S_CLEAR;
                  clr_rsp_in = 1'b1;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (dp_status.clr_last) begin
               cmd.rsp_clear = clr_rsp_ff;
               clr_rsp_in    = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // reset starts a clearing pass that posts no result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/bbdc_dpath.sv
// Datapath of the block bitmap duplicate checker: usage map RAM, counters,
// config registers and result registers. Depends on bbdc_pkg, bbdc_ram.
`timescale 1ns / 1ps
`default_nettype none

module bbdc_dpath #(
   parameter int MAX_BLOCKS = bbdc_pkg::DEF_MAX_BLOCKS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bbdc_pkg::ctrl_cmd_type            cmd,
   output bbdc_pkg::dp_status_type                dp_status,
   input  wire logic [bbdc_pkg::BLOCK_NUM_W-1:0]  req_block_number,
   input  wire logic [bbdc_pkg::CLASS_W-1:0]      req_block_class,
   input  wire logic                              csr_wr_en,
   input  wire logic                              csr_index,
   input  wire logic [bbdc_pkg::CNT_W-1:0]        csr_wr_data,
   output logic                                   rsp_valid,
   output logic      [bbdc_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [bbdc_pkg::DUP_W-1:0]        rsp_free_dup_count,
   output logic      [bbdc_pkg::CNT_W-1:0]        rsp_marked_count,
   output logic      [bbdc_pkg::CNT_W-1:0]        rsp_missing_count
);

   import bbdc_pkg::*;

   localparam int MAP_DEPTH = (MAX_BLOCKS + MAP_ROW_BITS - 1) / MAP_ROW_BITS;
   localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int MCW       = $clog2(MAX_BLOCKS + 1);
   localparam int LW        = (MCW > CNT_W) ? MCW : CNT_W;
   localparam logic [LW-1:0] MAX_LIM  = LW'(MAX_BLOCKS);
   localparam logic [AW-1:0] LAST_ROW = AW'(MAP_DEPTH - 1);

   // config registers
   logic [CNT_W-1:0] block_count_ff;
   logic             rebuild_mode_ff;

   // latched item
   logic [BLOCK_NUM_W-1:0] bn_ff;
   logic [CLASS_W-1:0]     cls_ff;

   // counters and clear pointer
   logic [DUP_W-1:0] dup_cnt_ff, dup_cnt_in;
   logic [MCW-1:0]   mark_cnt_ff, mark_cnt_in;
   logic [AW-1:0]    clr_ptr_ff;

   // result registers
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, status_in;
   logic [DUP_W-1:0]    rsp_dup_ff;
   logic [CNT_W-1:0]    rsp_marked_ff, rsp_missing_ff;
   logic [CNT_W-1:0]    marked_out, missing_out;

   // map RAM signals
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [MAP_ROW_BITS-1:0] ram_wr_data;
   logic [MAP_ROW_BITS-1:0] ram_rd_data;
   logic [MAP_ROW_BITS-1:0] bit_mask;

   // classification
   logic [LW-1:0] lim, mark_ext;
   logic          in_range, owned, seen, do_mark;

   bbdc_ram #(
      .WIDTH (MAP_ROW_BITS),
      .DEPTH (MAP_DEPTH),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.load_item),
      .rd_addr (req_block_number[AW+MAP_BIT_W-1:MAP_BIT_W]),
      .rd_data (ram_rd_data)
   );

   // config write port
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff  <= CNT_W'(65536);
         rebuild_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BLOCK_COUNT:  block_count_ff  <= csr_wr_data;
            CSR_REBUILD_MODE: rebuild_mode_ff <= csr_wr_data[0];
            default:          block_count_ff  <= block_count_ff;
         endcase
      end
   end

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         bn_ff  <= req_block_number;
         cls_ff <= req_block_class;
      end
   end

   // valid range capped at the map size
   always_comb begin
      lim = (LW'(block_count_ff) < MAX_LIM) ? LW'(block_count_ff) : MAX_LIM;
   end

   // classify the item against the fetched map row
   assign in_range = bn_ff < BLOCK_NUM_W'(lim);
   assign owned    = cls_ff[1];
   assign bit_mask = MAP_ROW_BITS'(1) << bn_ff[MAP_BIT_W-1:0];
   assign seen     = |(ram_rd_data & bit_mask);
   assign do_mark  = cmd.eval && in_range && !seen && (!rebuild_mode_ff || owned);

   always_comb begin
      status_in = ST_OK;
      if (!in_range) begin
         status_in = (cls_ff == CLASS_FREE) ? ST_RANGE_FREE : ST_RANGE;
      end else if (seen) begin
         status_in = owned ? ST_OWNED_DUP : ST_FREE_DUP;
      end
   end

   // map write: zero rows while clearing, set the bit on a first mark
   always_comb begin
      ram_wr_en   = cmd.clr_step || do_mark;
      ram_wr_addr = cmd.clr_step ? clr_ptr_ff : bn_ff[AW+MAP_BIT_W-1:MAP_BIT_W];
      ram_wr_data = cmd.clr_step ? '0 : (ram_rd_data | bit_mask);
   end

   // counter updates
   always_comb begin
      dup_cnt_in  = dup_cnt_ff;
      mark_cnt_in = mark_cnt_ff;
      if (cmd.clr_step) begin
         dup_cnt_in  = '0;
         mark_cnt_in = '0;
      end else if (cmd.eval) begin
         if (in_range && seen && !owned && (dup_cnt_ff != {DUP_W{1'b1}})) begin
            dup_cnt_in = dup_cnt_ff + DUP_W'(1);
         end
         if (do_mark) begin
            mark_cnt_in = mark_cnt_ff + MCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dup_cnt_ff  <= '0;
         mark_cnt_ff <= '0;
         clr_ptr_ff  <= '0;
      end else begin
         dup_cnt_ff  <= dup_cnt_in;
         mark_cnt_ff <= mark_cnt_in;
         if (cmd.clr_step) begin
            clr_ptr_ff <= (clr_ptr_ff == LAST_ROW) ? '0 : clr_ptr_ff + AW'(1);
         end
      end
   end

   assign dp_status.clr_last = (clr_ptr_ff == LAST_ROW);

   // result counts from the updated counters
   always_comb begin
      mark_ext    = LW'(mark_cnt_in);
      marked_out  = (mark_ext > LW'(CNT17_MAX)) ? CNT17_MAX : mark_ext[CNT_W-1:0];
      missing_out = (lim > mark_ext) ? CNT_W'(lim - mark_ext) : '0;
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.eval || cmd.rsp_clear;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval || cmd.rsp_clear) begin
         rsp_status_ff  <= cmd.eval ? status_in : ST_OK;
         rsp_dup_ff     <= dup_cnt_in;
         rsp_marked_ff  <= marked_out;
         rsp_missing_ff <= missing_out;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_free_dup_count = rsp_dup_ff;
   assign rsp_marked_count   = rsp_marked_ff;
   assign rsp_missing_count  = rsp_missing_ff;

endmodule

`default_nettype wire

### hw/rtl/block_bitmap_duplicate_checker_unit.sv
// Top level of the block bitmap duplicate checker.
// Depends on bbdc_pkg, bbdc_ctrl, bbdc_dpath (and bbdc_ram below it).
//
//   Channel   Ports                                          Handshake
//   request   req_operation, req_block_number, req_block_class  start & !busy
//   result    rsp_status, rsp_free_dup_count, rsp_marked_count,
//             rsp_missing_count                              rsp_valid, one cycle
//   config    csr_index, csr_wr_data                         csr_wr_en
//
// A mark beat first reads the map row from the RAM, then classifies the item,
// writes the row back and updates the counters; the result strobes in the
// following cycle. A clear beat sweeps the map one 32-bit row per cycle over
// ceil(MAX_BLOCKS/32) rows (2048 by default), then strobes its result.
// Reset runs the same sweep with busy high and posts no result.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module block_bitmap_duplicate_checker_unit #(
   parameter int MAX_BLOCKS = bbdc_pkg::DEF_MAX_BLOCKS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_operation,
   input  wire logic [bbdc_pkg::BLOCK_NUM_W-1:0]  req_block_number,
   input  wire logic [bbdc_pkg::CLASS_W-1:0]      req_block_class,
   output logic                                   rsp_valid,
   output logic      [bbdc_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [bbdc_pkg::DUP_W-1:0]        rsp_free_dup_count,
   output logic      [bbdc_pkg::CNT_W-1:0]        rsp_marked_count,
   output logic      [bbdc_pkg::CNT_W-1:0]        rsp_missing_count,
   input  wire logic                              csr_wr_en,
   input  wire logic                              csr_index,
   input  wire logic [bbdc_pkg::CNT_W-1:0]        csr_wr_data
);

   import bbdc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // sequencing
   bbdc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .busy          (busy),
      .cmd           (cmd),
      .dp_status     (dp_status)
   );

   // map, counters, registers
   bbdc_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .dp_status          (dp_status),
      .req_block_number   (req_block_number),
      .req_block_class    (req_block_class),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_free_dup_count (rsp_free_dup_count),
      .rsp_marked_count   (rsp_marked_count),
      .rsp_missing_count  (rsp_missing_count)
   );

endmodule

`default_nettype wire
